@@ sv/vbpc_pkg.sv @@
package vbpc_pkg;

    localparam int LINE_W  = 9;
    localparam int FRAME_W = 10;
    localparam int HPOS_W  = 10;
    localparam int VPOS_W  = 11;
    localparam int CLK_W   = 16;
    localparam int CNT_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [LINE_W-1:0]  LINE_LENGTH_RST   = 9'd227;
    localparam logic [FRAME_W-1:0] FRAME_LENGTH_RST  = 10'd312;
    localparam logic [FRAME_W-1:0] VIS_FIRST_RST     = 10'd44;
    localparam logic [FRAME_W-1:0] VIS_LAST_RST      = 10'd300;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIS_FIRST    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIS_LAST     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LL_TOGGLE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LF_TOGGLE    = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    // what the line-step unit reports for the current line
    typedef struct packed {
        logic [HPOS_W-1:0] hmax;
        logic              past_end;
        logic              fits;
        logic [HPOS_W-1:0] left;
        logic [CLK_W-1:0]  clocks_rem;
    } t_line_step;

endpackage

@@ sv/vbpc_if.sv @@
interface vbpc_in_if;
    logic                        valid;
    logic                        ready;
    logic [vbpc_pkg::CLK_W-1:0]  clock_count;

    modport source (output valid, output clock_count, input ready);
    modport sink   (input valid, input clock_count, output ready);
endinterface

interface vbpc_out_if;
    logic                        valid;
    logic                        ready;
    logic [vbpc_pkg::HPOS_W-1:0] horiz_pos;
    logic [vbpc_pkg::VPOS_W-1:0] vert_pos;
    logic                        long_line;
    logic                        long_frame;
    logic [vbpc_pkg::CNT_W-1:0]  frames_done;
    logic                        in_visible;
    logic [vbpc_pkg::HPOS_W-1:0] clocks_to_line_end;

    modport source (output valid, output horiz_pos, output vert_pos, output long_line,
                     output long_frame, output frames_done, output in_visible,
                     output clocks_to_line_end, input ready);
    modport sink   (input valid, input horiz_pos, input vert_pos, input long_line,
                     input long_frame, input frames_done, input in_visible,
                     input clocks_to_line_end, output ready);
endinterface

interface vbpc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [vbpc_pkg::CFG_IDX_W-1:0]   index;
    logic [vbpc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/vbpc_line_unit.sv @@
module vbpc_line_unit (
    input  logic [vbpc_pkg::LINE_W-1:0] i_line_length,
    input  logic                        i_long_line,
    input  logic [vbpc_pkg::HPOS_W-1:0] i_hpos,
    input  logic [vbpc_pkg::CLK_W-1:0]  i_clocks,
    output vbpc_pkg::t_line_step        o_step
);

    logic [vbpc_pkg::HPOS_W-1:0] w_hmax;
    logic [vbpc_pkg::HPOS_W-1:0] w_left;
    logic [vbpc_pkg::CLK_W-1:0]  w_left_ext;

    // current line length with the extra clock of a long line
    assign w_hmax = {1'b0, i_line_length} + {{(vbpc_pkg::HPOS_W-1){1'b0}}, i_long_line};
    assign w_left = w_hmax - i_hpos;
    assign w_left_ext = {{(vbpc_pkg::CLK_W-vbpc_pkg::HPOS_W){1'b0}}, w_left};

    always_comb begin
        o_step.hmax       = w_hmax;
        o_step.past_end   = (i_hpos >= w_hmax);
        o_step.left       = w_left;
        o_step.fits       = (i_clocks < w_left_ext);
        o_step.clocks_rem = i_clocks - w_left_ext;
    end

endmodule

@@ sv/video_beam_position_counter.sv @@
// an input word is taken only in idle; the run state then steps through the line ends crossed
// and the final partial line, and registers the result once the output register is free
// no new word is taken until the result is registered and the block is back in idle
// the line-step unit retires one line (or the final partial line) per cycle
// reset: synchronous, active low; registers to defaults, position and counters zero
module video_beam_position_counter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    vbpc_in_if.sink           i_in,
    vbpc_out_if.source        o_out,
    vbpc_cfg_if.sink          i_cfg
);

    vbpc_pkg::t_state r_state, n_state;

    logic [vbpc_pkg::LINE_W-1:0]  r_line_length, n_line_length;
    logic [vbpc_pkg::FRAME_W-1:0] r_frame_length, n_frame_length;
    logic [vbpc_pkg::FRAME_W-1:0] r_vis_first, n_vis_first;
    logic [vbpc_pkg::FRAME_W-1:0] r_vis_last, n_vis_last;
    logic                         r_ll_toggle, n_ll_toggle;
    logic                         r_lf_toggle, n_lf_toggle;

    logic [vbpc_pkg::HPOS_W-1:0]  r_hpos, n_hpos;
    logic [vbpc_pkg::VPOS_W-1:0]  r_vpos, n_vpos;
    logic                         r_ll_flag, n_ll_flag;
    logic                         r_lf_flag, n_lf_flag;
    logic [vbpc_pkg::CNT_W-1:0]   r_frames, n_frames;
    logic [vbpc_pkg::CLK_W-1:0]   r_clocks, n_clocks;

    logic                         r_out_valid, n_out_valid;
    logic [vbpc_pkg::HPOS_W-1:0]  r_o_hpos, n_o_hpos;
    logic [vbpc_pkg::VPOS_W-1:0]  r_o_vpos, n_o_vpos;
    logic                         r_o_ll, n_o_ll;
    logic                         r_o_lf, n_o_lf;
    logic [vbpc_pkg::CNT_W-1:0]   r_o_frames, n_o_frames;
    logic                         r_o_vis, n_o_vis;
    logic [vbpc_pkg::HPOS_W-1:0]  r_o_left, n_o_left;

    vbpc_pkg::t_line_step         w_step;
    logic                         w_in_acc;
    logic                         w_zero_geom;
    logic [vbpc_pkg::VPOS_W-1:0]  w_eol_vpos;
    logic [vbpc_pkg::VPOS_W-1:0]  w_frame_len;
    logic                         w_frame_wrap;

    vbpc_line_unit u_line_unit (
        .i_line_length (r_line_length),
        .i_long_line   (r_ll_flag),
        .i_hpos        (r_hpos),
        .i_clocks      (r_clocks),
        .o_step        (w_step)
    );

    assign i_in.ready  = (r_state == vbpc_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid && (r_state == vbpc_pkg::ST_IDLE);
    assign w_zero_geom = (r_line_length == '0) || (r_frame_length == '0);

    assign w_eol_vpos   = r_vpos + {{(vbpc_pkg::VPOS_W-1){1'b0}}, 1'b1};
    assign w_frame_len  = {1'b0, r_frame_length} + {{(vbpc_pkg::VPOS_W-1){1'b0}}, r_lf_flag};
    assign w_frame_wrap = (w_eol_vpos >= w_frame_len);

    assign o_out.valid              = r_out_valid;
    assign o_out.horiz_pos          = r_o_hpos;
    assign o_out.vert_pos           = r_o_vpos;
    assign o_out.long_line          = r_o_ll;
    assign o_out.long_frame         = r_o_lf;
    assign o_out.frames_done        = r_o_frames;
    assign o_out.in_visible         = r_o_vis;
    assign o_out.clocks_to_line_end = r_o_left;

    always_comb begin
        n_state        = r_state;
        n_line_length  = r_line_length;
        n_frame_length = r_frame_length;
        n_vis_first    = r_vis_first;
        n_vis_last     = r_vis_last;
        n_ll_toggle    = r_ll_toggle;
        n_lf_toggle    = r_lf_toggle;
        n_hpos         = r_hpos;
        n_vpos         = r_vpos;
        n_ll_flag      = r_ll_flag;
        n_lf_flag      = r_lf_flag;
        n_frames       = r_frames;
        n_clocks       = r_clocks;
        n_out_valid    = r_out_valid && !o_out.ready;
        n_o_hpos       = r_o_hpos;
        n_o_vpos       = r_o_vpos;
        n_o_ll         = r_o_ll;
        n_o_lf         = r_o_lf;
        n_o_frames     = r_o_frames;
        n_o_vis        = r_o_vis;
        n_o_left       = r_o_left;

        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                vbpc_pkg::CFG_LINE_LENGTH:  n_line_length  = i_cfg.data[vbpc_pkg::LINE_W-1:0];
                vbpc_pkg::CFG_FRAME_LENGTH: n_frame_length = i_cfg.data;
                vbpc_pkg::CFG_VIS_FIRST:    n_vis_first    = i_cfg.data;
                vbpc_pkg::CFG_VIS_LAST:     n_vis_last     = i_cfg.data;
                vbpc_pkg::CFG_LL_TOGGLE:    n_ll_toggle    = i_cfg.data[0];
                vbpc_pkg::CFG_LF_TOGGLE:    n_lf_toggle    = i_cfg.data[0];
                default: ;
            endcase
        end

        unique case (r_state)
            vbpc_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_clocks = i_in.clock_count;
                    n_state  = vbpc_pkg::ST_RUN;
                    // zero geometry falls back to the defaults with cleared state
                    if (w_zero_geom) begin
                        n_line_length  = vbpc_pkg::LINE_LENGTH_RST;
                        n_frame_length = vbpc_pkg::FRAME_LENGTH_RST;
                        n_vis_first    = vbpc_pkg::VIS_FIRST_RST;
                        n_vis_last     = vbpc_pkg::VIS_LAST_RST;
                        n_ll_toggle    = 1'b0;
                        n_lf_toggle    = 1'b0;
                        n_hpos         = '0;
                        n_vpos         = '0;
                        n_ll_flag      = 1'b0;
                        n_lf_flag      = 1'b0;
                        n_frames       = '0;
                    end
                end
            end
            vbpc_pkg::ST_RUN: begin
                if (r_clocks == '0) begin
                    if (!r_out_valid || o_out.ready) begin
                        n_out_valid = 1'b1;
                        n_o_hpos    = r_hpos;
                        n_o_vpos    = r_vpos;
                        n_o_ll      = r_ll_flag;
                        n_o_lf      = r_lf_flag;
                        n_o_frames  = r_frames;
                        n_o_vis     = ({1'b0, r_vis_first} <= r_vpos)
                                      && (r_vpos <= {1'b0, r_vis_last});
                        n_o_left    = w_step.past_end ? '0 : w_step.left;
                        n_state     = vbpc_pkg::ST_IDLE;
                    end
                end else if (!w_step.past_end && w_step.fits) begin
                    // advance stops inside the line
                    n_hpos   = r_hpos + r_clocks[vbpc_pkg::HPOS_W-1:0];
                    n_clocks = '0;
                end else begin
                    // line end, with or without clocks spent on it
                    if (!w_step.past_end) begin
                        n_clocks = w_step.clocks_rem;
                    end
                    n_hpos    = '0;
                    n_vpos    = w_frame_wrap ? '0 : w_eol_vpos;
                    n_ll_flag = r_ll_toggle && !r_ll_flag;
                    if (w_frame_wrap) begin
                        n_frames  = r_frames + 32'd1;
                        n_lf_flag = r_lf_toggle && !r_lf_flag;
                    end
                end
            end
            default: n_state = vbpc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= vbpc_pkg::ST_IDLE;
            r_line_length  <= vbpc_pkg::LINE_LENGTH_RST;
            r_frame_length <= vbpc_pkg::FRAME_LENGTH_RST;
            r_vis_first    <= vbpc_pkg::VIS_FIRST_RST;
            r_vis_last     <= vbpc_pkg::VIS_LAST_RST;
            r_ll_toggle    <= 1'b0;
            r_lf_toggle    <= 1'b0;
            r_hpos         <= '0;
            r_vpos         <= '0;
            r_ll_flag      <= 1'b0;
            r_lf_flag      <= 1'b0;
            r_frames       <= '0;
            r_clocks       <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_line_length  <= n_line_length;
            r_frame_length <= n_frame_length;
            r_vis_first    <= n_vis_first;
            r_vis_last     <= n_vis_last;
            r_ll_toggle    <= n_ll_toggle;
            r_lf_toggle    <= n_lf_toggle;
            r_hpos         <= n_hpos;
            r_vpos         <= n_vpos;
            r_ll_flag      <= n_ll_flag;
            r_lf_flag      <= n_lf_flag;
            r_frames       <= n_frames;
            r_clocks       <= n_clocks;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_hpos   <= n_o_hpos;
        r_o_vpos   <= n_o_vpos;
        r_o_ll     <= n_o_ll;
        r_o_lf     <= n_o_lf;
        r_o_frames <= n_o_frames;
        r_o_vis    <= n_o_vis;
        r_o_left   <= n_o_left;
    end

endmodule

@@ sv/vbpc_checker.sv @@
module vbpc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [vbpc_pkg::HPOS_W-1:0] i_horiz_pos,
    input logic [vbpc_pkg::VPOS_W-1:0] i_vert_pos,
    input logic [vbpc_pkg::CNT_W-1:0]  i_frames_done,
    input logic [vbpc_pkg::HPOS_W-1:0] i_clocks_to_line_end
);

    // no word pending straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a taken input word keeps the input side closed while it runs
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready while a word is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_horiz_pos) && $stable(i_vert_pos)
            && $stable(i_frames_done) && $stable(i_clocks_to_line_end)))
        else $error("result changed while stalled");

endmodule

bind video_beam_position_counter vbpc_checker u_vbpc_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_in.valid),
    .i_in_ready           (i_in.ready),
    .i_out_valid          (o_out.valid),
    .i_out_ready          (o_out.ready),
    .i_horiz_pos          (o_out.horiz_pos),
    .i_vert_pos           (o_out.vert_pos),
    .i_frames_done        (o_out.frames_done),
    .i_clocks_to_line_end (o_out.clocks_to_line_end)
);
